>>> rtl/aidt_pkg.sv
// Shared types, constants and helpers for the aging identifier table.
// Used by the top level and the testbench; depends on nothing.
package aidt_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int ID_W    = 22;
    localparam int STAMP_W = 32;
    localparam int HITS_W  = 8;
    localparam int OUT_W   = 5;

    // Operation codes
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_EXPIRE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EXPIRED  = 3'd3;
    localparam logic [2:0] ST_TICKED   = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_EXPIRE_AGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_HITS  = 1'd1;

    localparam logic [STAMP_W-1:0] EXPIRE_AGE_RST = 32'd300;
    localparam logic [HITS_W-1:0]  KEEP_HITS_RST  = 8'd5;
    localparam logic [HITS_W-1:0]  HITS_MAX       = 8'd255;

    typedef struct packed {
        logic [1:0]      op;
        logic [ID_W-1:0] ident;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [HITS_W-1:0] hits;
        logic [OUT_W-1:0]  removed;
        logic [OUT_W-1:0]  occupancy;
    } out_item_t;

    // One table slot as stored in RAM
    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [STAMP_W-1:0] stamp;
        logic [HITS_W-1:0]  hits;
    } entry_t;

    // Clamp an entry count to the 5-bit result fields
    function automatic logic [OUT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        if (int'(v) > 31)
            return 5'd31;
        else
            return OUT_W'(v);
    endfunction

endpackage

>>> rtl/aging_id_table_with_hit_count_unit.sv
// Top level of the aging identifier table with hit counts.
// Depends on aidt_pkg and aidt_ram.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one operation per
//   item: record an identifier, expire old entries, advance the tick counter
//   or clear the table. Output channel (out_valid / out_stall / out_item)
//   returns exactly one result item per operation, in order.
//   Record and expire sweep the table one slot per cycle through the single
//   read port of the slot RAM, then record writes the hit or new entry;
//   tick and clear skip the sweep and go straight to the output stage.
//   The block takes one item at a time; in_stall is high while an item is
//   being worked on, until its result is loaded into the output register.
//   A finished result waits in the output register while the next item is
//   accepted; if the receiver stalls, the block holds its result and waits
//   before writing the next one.
//   Reset empties the table (valid bits only, no clearing pass), zeroes the
//   tick counter and loads expire_age = 300 and keep_hits = 5.
//   Configuration writes (cfg_we / cfg_index / cfg_data) take effect at once;
//   the user must make them while the block is idle; the block does not enforce it.
module aging_id_table_with_hit_count_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  aidt_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output aidt_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [aidt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aidt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import aidt_pkg::*;

    localparam int SCAN_W = IDX_W + 1;
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [STAMP_W-1:0]   now_reg, now_next;
    logic [STAMP_W-1:0]   expire_age_reg, expire_age_next;
    logic [HITS_W-1:0]    keep_hits_reg, keep_hits_next;

    logic [1:0]           op_reg, op_next;
    logic [ID_W-1:0]      ident_reg, ident_next;
    logic [SCAN_W-1:0]    cnt_reg, cnt_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     found_idx_reg, found_idx_next;
    logic [HITS_W-1:0]    found_hits_reg, found_hits_next;
    logic                 free_reg, free_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;

    logic [2:0]           res_status_reg, res_status_next;
    logic [HITS_W-1:0]    res_hits_reg, res_hits_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;

    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    entry_t               ram_rdata;
    logic [IDX_W-1:0]     ram_raddr;

    logic                 in_take;
    logic [STAMP_W-1:0]   age;
    logic [HITS_W-1:0]    hits_inc;

    aidt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Shared sweep unit: age of the slot under check and saturating hit bump
    assign ram_raddr = cnt_reg[IDX_W-1:0];
    assign age       = now_reg - ram_rdata.stamp;
    assign hits_inc  = (found_hits_reg == HITS_MAX) ? HITS_MAX : found_hits_reg + 8'd1;

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        now_next        = now_reg;
        expire_age_next = expire_age_reg;
        keep_hits_next  = keep_hits_reg;
        op_next         = op_reg;
        ident_next      = ident_reg;
        cnt_next        = cnt_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_hits_next = found_hits_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_hits_next   = res_hits_reg;
        removed_next    = removed_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        ram_we          = 1'b0;
        ram_waddr       = found_idx_reg;
        ram_wdata       = '0;

        // Register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPIRE_AGE: expire_age_next = cfg_data;
                REG_KEEP_HITS:  keep_hits_next  = cfg_data[HITS_W-1:0];
                default: ;
            endcase
        end

        // Drop the result once the receiver takes it
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next       = in_item.op;
                    ident_next    = in_item.ident;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    free_next     = 1'b0;
                    removed_next  = '0;
                    res_hits_next = '0;
                    unique case (in_item.op)
                        OP_RECORD, OP_EXPIRE:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_TICK:
                        begin
                            now_next        = now_reg + 32'd1;
                            res_status_next = ST_TICKED;
                            state_next      = S_EMIT;
                        end
                        default:
                        begin
                            removed_next    = occ_reg;
                            valid_next      = '0;
                            occ_next        = '0;
                            res_status_next = ST_CLEARED;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next slot read
                if (cnt_reg != SCAN_LAST)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = cnt_reg[IDX_W-1:0];
                    cnt_next       = cnt_reg + SCAN_W'(1);
                end
                // Check the slot whose data just came back
                if (chk_valid_reg)
                begin
                    if (op_reg == OP_RECORD)
                    begin
                        if (valid_reg[chk_idx_reg])
                        begin
                            if (!found_reg && ram_rdata.ident == ident_reg)
                            begin
                                found_next      = 1'b1;
                                found_idx_next  = chk_idx_reg;
                                found_hits_next = ram_rdata.hits;
                            end
                        end
                        else if (!free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = chk_idx_reg;
                        end
                    end
                    else if (valid_reg[chk_idx_reg] && age > expire_age_reg
                             && ram_rdata.hits < keep_hits_reg)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        occ_next     = occ_reg - CNT_W'(1);
                        removed_next = removed_reg + CNT_W'(1);
                    end
                end
                if (cnt_reg == SCAN_LAST)
                begin
                    if (op_reg == OP_RECORD)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        res_status_next = ST_EXPIRED;
                        state_next      = S_EMIT;
                    end
                end
            end

            S_WRITE:
            begin
                // Refresh a hit, insert a miss, or report full
                if (found_reg)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = found_idx_reg;
                    ram_wdata       = '{ident: ident_reg, stamp: now_reg, hits: hits_inc};
                    res_hits_next   = hits_inc;
                    res_status_next = ST_HIT;
                end
                else if (free_reg)
                begin
                    ram_we                   = 1'b1;
                    ram_waddr                = free_idx_reg;
                    ram_wdata                = '{ident: ident_reg, stamp: now_reg, hits: '0};
                    valid_next[free_idx_reg] = 1'b1;
                    occ_next                 = occ_reg + CNT_W'(1);
                    res_status_next          = ST_INSERTED;
                end
                else
                begin
                    res_status_next = ST_FULL;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_item_next.status    = res_status_reg;
                    out_item_next.hits      = res_hits_reg;
                    out_item_next.removed   = sat_cnt(removed_reg);
                    out_item_next.occupancy = sat_cnt(occ_reg);
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            occ_reg        <= '0;
            now_reg        <= '0;
            expire_age_reg <= EXPIRE_AGE_RST;
            keep_hits_reg  <= KEEP_HITS_RST;
            cnt_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            now_reg        <= now_next;
            expire_age_reg <= expire_age_next;
            keep_hits_reg  <= keep_hits_next;
            cnt_reg        <= cnt_next;
            chk_valid_reg  <= chk_valid_next;
            found_reg      <= found_next;
            free_reg       <= free_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        ident_reg      <= ident_next;
        chk_idx_reg    <= chk_idx_next;
        found_idx_reg  <= found_idx_next;
        found_hits_reg <= found_hits_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_hits_reg   <= res_hits_next;
        removed_reg    <= removed_next;
        out_item_reg   <= out_item_next;
    end

`ifndef SYNTHESIS
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == CNT_W'($countones(valid_reg)))
        else $error("occupancy count out of step with valid bits");

    a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) <= ENTRIES)
        else $error("occupancy above table size");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && in_item.op == OP_CLEAR |=> valid_reg == '0)
        else $error("clear left valid entries");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && in_item.op == OP_TICK |=> now_reg == $past(now_reg) + 32'd1)
        else $error("tick did not advance time");

    a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> state_reg == S_SCAN)
        else $error("slot check outside the sweep");
`endif

endmodule

>>> rtl/aidt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the per-slot identifier, stamp and hit count.
module aidt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the aging identifier table with hit counts.
// Holds its own table predictor and checks every result item in order; needs
// aidt_pkg and aging_id_table_with_hit_count_unit.
`timescale 1ns / 1ps

module tb;
    import aidt_pkg::*;

    localparam int TIMEOUT_NS  = 4000000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYC  = 24;

    // DUT connections
    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted table contents and settings
    logic               slot_valid [ENTRIES];
    logic [ID_W-1:0]    slot_ident [ENTRIES];
    logic [STAMP_W-1:0] slot_stamp [ENTRIES];
    logic [HITS_W-1:0]  slot_hits [ENTRIES];
    logic [STAMP_W-1:0] tick_now;
    logic [STAMP_W-1:0] age_limit;
    logic [HITS_W-1:0]  keep_threshold;

    // Results still owed by the block, oldest first
    out_item_t pending_results[$];
    out_item_t head_result;

    int  error_count = 0;
    int  items_sent = 0;
    int  status_seen [8];
    int  swept_total = 0;
    bit  idle_enable = 1'b1;
    int  stall_left = 0;

    // Identifier pool and operation mix for the random stretches
    logic [ID_W-1:0] id_pool [32];
    int  pool_size = 8;
    int  tick_pct = 20;
    int  expire_pct = 10;
    int  clear_pct = 2;

    aging_id_table_with_hit_count_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Compute the result of one table operation and update the predicted table
    function automatic out_item_t predict_table_op(input in_item_t it);
        out_item_t          res;
        int                 found;
        int                 free_slot;
        int                 n_removed;
        int                 n_valid;
        logic [STAMP_W-1:0] age;
        res = '0;
        found = -1;
        free_slot = -1;
        n_removed = 0;
        n_valid = 0;
        case (it.op)
            OP_RECORD:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_valid[i])
                    begin
                        if (found < 0 && slot_ident[i] == it.ident)
                            found = i;
                    end
                    else if (free_slot < 0)
                        free_slot = i;
                end
                if (found >= 0)
                begin
                    slot_stamp[found] = tick_now;
                    if (slot_hits[found] != HITS_MAX)
                        slot_hits[found] = slot_hits[found] + 1'b1;
                    res.hits = slot_hits[found];
                    res.status = ST_HIT;
                end
                else if (free_slot >= 0)
                begin
                    slot_valid[free_slot] = 1'b1;
                    slot_ident[free_slot] = it.ident;
                    slot_stamp[free_slot] = tick_now;
                    slot_hits[free_slot] = '0;
                    res.status = ST_INSERTED;
                end
                else
                    res.status = ST_FULL;
            end
            OP_EXPIRE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    age = tick_now - slot_stamp[i];
                    if (slot_valid[i] && age > age_limit && slot_hits[i] < keep_threshold)
                    begin
                        slot_valid[i] = 1'b0;
                        n_removed++;
                    end
                end
                res.status = ST_EXPIRED;
            end
            OP_TICK:
            begin
                tick_now = tick_now + 1'b1;
                res.status = ST_TICKED;
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_valid[i])
                        n_removed++;
                    slot_valid[i] = 1'b0;
                end
                res.status = ST_CLEARED;
            end
        endcase
        for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i])
                n_valid++;
        res.removed = (n_removed > 31) ? OUT_W'(31) : OUT_W'(n_removed);
        res.occupancy = (n_valid > 31) ? OUT_W'(31) : OUT_W'(n_valid);
        return res;
    endfunction

    // Pick an item from the current operation mix and identifier pool
    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0)
            it.ident = ID_W'($urandom());
        else
            it.ident = id_pool[$urandom_range(0, pool_size - 1)];
        if (pick < tick_pct)
            it.op = OP_TICK;
        else if (pick < tick_pct + expire_pct)
            it.op = OP_EXPIRE;
        else if (pick < tick_pct + expire_pct + clear_pct)
            it.op = OP_CLEAR;
        else
            it.op = OP_RECORD;
        return it;
    endfunction

    // Fill the identifier pool with fresh random values
    task automatic build_pool(input int n);
        pool_size = n;
        for (int i = 0; i < n; i++)
            id_pool[i] = ID_W'($urandom());
    endtask

    // Offer one item, hold it until accepted, then queue its expected result
    task automatic send_op(input logic [1:0] op, input logic [ID_W-1:0] ident);
        in_item_t it;
        int       gap;
        it.op = op;
        it.ident = ident;
        gap = 0;
        if (idle_enable && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_table_op(it));
        items_sent++;
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT)
        begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write one configuration register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_EXPIRE_AGE)
            age_limit = data;
        else if (idx == REG_KEEP_HITS)
            keep_threshold = data[HITS_W-1:0];
    endtask

    // Receiver stalls in random bursts while idling is enabled
    always @(posedge clk)
    begin
        if (!idle_enable)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none actual %h", $time, out_item);
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (out_item.status !== head_result.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, head_result.status, out_item.status);
                end
                if (out_item.hits !== head_result.hits)
                begin
                    error_count++;
                    $display("%0t: hits mismatch, expected %0d actual %0d",
                             $time, head_result.hits, out_item.hits);
                end
                if (out_item.removed !== head_result.removed)
                begin
                    error_count++;
                    $display("%0t: removed mismatch, expected %0d actual %0d",
                             $time, head_result.removed, out_item.removed);
                end
                if (out_item.occupancy !== head_result.occupancy)
                begin
                    error_count++;
                    $display("%0t: occupancy mismatch, expected %0d actual %0d",
                             $time, head_result.occupancy, out_item.occupancy);
                end
                status_seen[head_result.status]++;
                if (head_result.status == ST_EXPIRED)
                    swept_total += head_result.removed;
            end
        end
    end

    // Each operation at least once, identifier extremes and ignored ident bits
    task automatic test_basic_ops();
        send_op(OP_RECORD, '0);
        send_op(OP_RECORD, '1);
        send_op(OP_RECORD, '0);
        send_op(OP_TICK, 22'h3C3C3C);
        send_op(OP_EXPIRE, 22'h2AAAAA);
        send_op(OP_CLEAR, 22'h155555);
    endtask

    // Fill every slot, overflow once, hit an entry of a full table, then clear
    task automatic test_table_full();
        for (int i = 0; i < ENTRIES; i++)
            send_op(OP_RECORD, ID_W'(i * 22'h040001 + 7));
        send_op(OP_RECORD, 22'h3FFFFE);
        send_op(OP_RECORD, ID_W'(5 * 22'h040001 + 7));
        send_op(OP_CLEAR, '0);
    endtask

    // Zero age limit with the highest keep threshold, then a zero threshold
    task automatic test_expire_extremes();
        wait_idle();
        write_reg(REG_EXPIRE_AGE, '0);
        write_reg(REG_KEEP_HITS, 32'd255);
        send_op(OP_RECORD, 22'h123456);
        send_op(OP_EXPIRE, '0);
        send_op(OP_TICK, '0);
        send_op(OP_EXPIRE, '0);
        wait_idle();
        write_reg(REG_KEEP_HITS, '0);
        send_op(OP_RECORD, 22'h123456);
        send_op(OP_TICK, '0);
        send_op(OP_TICK, '0);
        send_op(OP_EXPIRE, '0);
        send_op(OP_CLEAR, '0);
    endtask

    // Reset settings: entries age past 300 ticks, frequent ones survive
    task automatic test_default_aging();
        wait_idle();
        write_reg(REG_EXPIRE_AGE, 32'd300);
        write_reg(REG_KEEP_HITS, 32'd5);
        build_pool(8);
        send_op(OP_CLEAR, '0);
        for (int i = 0; i < 8; i++)
            send_op(OP_RECORD, id_pool[i]);
        for (int i = 0; i < 8; i++)
            repeat ((i < 4) ? 5 : 2) send_op(OP_RECORD, id_pool[i]);
        repeat (300) send_op(OP_TICK, ID_W'($urandom()));
        send_op(OP_EXPIRE, '0);
        send_op(OP_TICK, '0);
        send_op(OP_EXPIRE, '0);
        // refill the lowest free slot, then touch a survivor
        send_op(OP_RECORD, id_pool[5]);
        send_op(OP_RECORD, id_pool[0]);
    endtask

    // Drive one identifier past 255 hits and keep it through a sweep
    task automatic test_hit_saturation();
        logic [ID_W-1:0] hot_id;
        int              hot_count;
        int              pick;
        hot_id = ID_W'($urandom());
        hot_count = 0;
        wait_idle();
        write_reg(REG_EXPIRE_AGE, '0);
        write_reg(REG_KEEP_HITS, 32'd255);
        send_op(OP_CLEAR, '0);
        while (hot_count < 258)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_op(OP_TICK, '0);
            else if (pick == 1)
                send_op(OP_RECORD, ID_W'($urandom()));
            else
            begin
                send_op(OP_RECORD, hot_id);
                hot_count++;
            end
        end
        send_op(OP_TICK, '0);
        send_op(OP_EXPIRE, '0);
        send_op(OP_RECORD, hot_id);
    endtask

    // Phases of random traffic under different register settings
    task automatic test_random_phases();
        in_item_t        it;
        logic [31:0]     age_val;
        logic [31:0]     keep_val;
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            case (ph)
                0: begin age_val = '0; keep_val = 32'd255; end
                1: begin age_val = '1; keep_val = 32'd255; end
                2: begin age_val = 32'd1; keep_val = '0; end
                3: begin age_val = $urandom(); keep_val = $urandom(); end
                default:
                begin
                    age_val = $urandom_range(0, 15);
                    keep_val = $urandom_range(1, 6);
                end
            endcase
            // upper data bits of the narrow register carry noise in odd phases
            if (ph % 2 == 1)
                keep_val = ($urandom() & 32'hFFFFFF00) | (keep_val & 32'hFF);
            write_reg(REG_EXPIRE_AGE, age_val);
            write_reg(REG_KEEP_HITS, keep_val);
            build_pool($urandom_range(6, 28));
            tick_pct = $urandom_range(10, 35);
            expire_pct = $urandom_range(5, 15);
            clear_pct = $urandom_range(1, 4);
            idle_enable = (ph != 5);
            repeat (80)
            begin
                it = random_item();
                send_op(it.op, it.ident);
            end
        end
        idle_enable = 1'b1;
    endtask

    // Closing stretch with no idling on either side
    task automatic test_back_to_back();
        in_item_t it;
        wait_idle();
        write_reg(REG_EXPIRE_AGE, 32'd3);
        write_reg(REG_KEEP_HITS, 32'd2);
        build_pool(20);
        tick_pct = 25;
        expire_pct = 10;
        clear_pct = 2;
        idle_enable = 1'b0;
        repeat (100)
        begin
            it = random_item();
            send_op(it.op, it.ident);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_ident[i] = '0;
            slot_stamp[i] = '0;
            slot_hits[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        tick_now = '0;
        age_limit = EXPIRE_AGE_RST;
        keep_threshold = KEEP_HITS_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_table_full();
        test_expire_extremes();
        test_default_aging();
        test_hit_saturation();
        test_random_phases();
        test_back_to_back();
        wait_idle();

        $display("tb: %0d items: %0d hits, %0d inserts, %0d full, %0d ticks",
                 items_sent, status_seen[ST_HIT], status_seen[ST_INSERTED],
                 status_seen[ST_FULL], status_seen[ST_TICKED]);
        $display("tb: %0d sweeps removed %0d entries, %0d clears, %0d errors",
                 status_seen[ST_EXPIRED], swept_total, status_seen[ST_CLEARED], error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
